FILE: rtl/delta_history_bar_graph_unit_defines.svh
// Assertion macros shared by the delta history bar graph RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef DELTA_HISTORY_BAR_GRAPH_UNIT_DEFINES_SVH
`define DELTA_HISTORY_BAR_GRAPH_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DHBG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DHBG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/dhbg_pkg.sv
// Types and constants for the delta history bar graph unit.
// No dependencies; imported by dhbg_div and the top-level module.
`default_nettype none

package dhbg_pkg;

   localparam int SAMPLE_W  = 64;
   localparam int HEIGHT_W  = 10;
   localparam int COLUMN_W  = 6;
   localparam int CSR_IDX_W = 2;
   localparam int DIV_CNT_W = 6;

   localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT_RESET = 10'd64;
   localparam logic [SAMPLE_W-1:0] FULL_SCALE_RESET   = 64'd1;

   // register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SCALE   = 2'd1;

   // request kinds
   localparam logic KIND_ADD  = 1'b0;
   localparam logic KIND_DRAW = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_DIV
   } dhbg_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

FILE: rtl/dhbg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dhbg_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/dhbg_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit operands.
// Depends on dhbg_pkg and the assertion macro header.
`default_nettype none
`include "delta_history_bar_graph_unit_defines.svh"

module dhbg_div
   import dhbg_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [SAMPLE_W-1:0] dividend,
   input  wire logic [SAMPLE_W-1:0] divisor,
   output logic      [SAMPLE_W-1:0] quotient,
   output div_status_type           status
);

   logic [SAMPLE_W-1:0]  rem_ff, rem_in;
   logic [SAMPLE_W-1:0]  quo_ff, quo_in;
   logic [SAMPLE_W-1:0]  dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [SAMPLE_W:0]    rem_sh;
   logic [SAMPLE_W+1:0]  diff;
   logic                 take;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[SAMPLE_W-1]};
      diff    = {1'b0, rem_sh} - {2'b00, dvs_ff};
      take    = ~diff[SAMPLE_W+1];
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = DIV_CNT_W'(SAMPLE_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // a zero divisor always takes, giving an all-ones quotient
         rem_in = take ? diff[SAMPLE_W-1:0] : rem_sh[SAMPLE_W-1:0];
         quo_in = {quo_ff[SAMPLE_W-2:0], take};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   `DHBG_ASSERT_NEXT(a_div_start_busy, clock, reset, start, busy_ff, "divider did not start")
   `DHBG_ASSERT_SAME(a_div_done_idle, clock, reset, done_ff, !busy_ff, "done while busy")
   `DHBG_ASSERT_NEXT(a_div_done_pulse, clock, reset, done_ff && !start, !done_ff, "done held")

endmodule

`default_nettype wire

FILE: rtl/delta_history_bar_graph_unit.sv
// Top level of the delta history bar graph unit: sequencer, ring store, scaling.
// Depends on dhbg_pkg, dhbg_ram, dhbg_div and the assertion macro header.
//
// Usage:
//   Request channel: a beat is taken at a rising edge with start high and busy
//   low. req_kind selects add (store req_sample minus the previous sample in
//   the ring, advance the write index) or draw (read out all DEPTH bars).
//   An add gives no result and leaves busy low.
//   A draw raises busy; each bar passes ST_READ (ring read), ST_MUL (multiply
//   by the height limit) and ST_DIV (bit-serial division by full scale); the
//   next bar starts when the divider is done, and the last bar appears in the
//   cycle busy falls. Result channel: rsp_valid is high for one cycle per bar,
//   the slot at the write index (the oldest entry once the ring is full) at
//   column zero, rsp_last on the final bar. The receiver cannot stall.
//   Configuration: csr_valid/csr_ready write beat, always ready; index 0 is
//   the height limit, 1 the full scale, others are ignored. Write only idle.
//   Reset (synchronous) clears the ring through per-entry valid bits, zeroes
//   the previous sample and write index, and loads the register defaults.
`default_nettype none
`include "delta_history_bar_graph_unit_defines.svh"

module delta_history_bar_graph_unit
   import dhbg_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic                 req_kind,
   input  wire logic [SAMPLE_W-1:0]  req_sample,
   output logic                      rsp_valid,
   output logic      [COLUMN_W-1:0]  rsp_column,
   output logic      [HEIGHT_W-1:0]  rsp_bar_height,
   output logic                      rsp_last,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [SAMPLE_W-1:0]  csr_data
);

   localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(DEPTH - 1);

   dhbg_state_type      state_ff, state_in;
   logic [IDXW-1:0]     wr_idx_ff;
   logic [SAMPLE_W-1:0] prev_ff;
   logic [DEPTH-1:0]    valid_ff;
   logic [IDXW-1:0]     slot_ff, slot_in;
   logic [IDXW-1:0]     col_ff, col_in;
   logic                entry_ok_ff;
   logic [HEIGHT_W-1:0] limit_ff;
   logic [SAMPLE_W-1:0] scale_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COLUMN_W-1:0] rsp_column_ff, rsp_column_in;
   logic [HEIGHT_W-1:0] rsp_height_ff, rsp_height_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                accept;
   logic                add_go;
   logic                csr_we;
   logic                rd_en;
   logic [SAMPLE_W-1:0] rd_data;
   logic [SAMPLE_W-1:0] entry;
   logic [SAMPLE_W-1:0] product;
   logic                div_start;
   logic [SAMPLE_W-1:0] quotient;
   div_status_type      div_status;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign add_go    = accept && (req_kind == KIND_ADD);
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   // never-written entries read as zero
   assign entry   = entry_ok_ff ? rd_data : '0;
   assign product = entry * SAMPLE_W'(limit_ff);

   dhbg_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (add_go),
      .wr_addr (wr_idx_ff),
      .wr_data (req_sample - prev_ff),
      .rd_en   (rd_en),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   dhbg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (scale_ff),
      .quotient (quotient),
      .status   (div_status)
   );

   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      col_in        = col_ff;
      rsp_valid_in  = 1'b0;
      rsp_column_in = rsp_column_ff;
      rsp_height_in = rsp_height_ff;
      rsp_last_in   = rsp_last_ff;
      rd_en         = 1'b0;
      div_start     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_kind == KIND_DRAW)) begin
               slot_in  = wr_idx_ff;
               col_in   = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_status.done) begin
               rsp_valid_in  = 1'b1;
               rsp_column_in = COLUMN_W'(col_ff);
               // cap at the height limit
               rsp_height_in = (quotient > SAMPLE_W'(limit_ff)) ? limit_ff
                                                               : quotient[HEIGHT_W-1:0];
               rsp_last_in   = (col_ff == LAST_IDX);
               if (col_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end else begin
                  col_in   = col_ff + 1'b1;
                  slot_in  = (slot_ff == LAST_IDX) ? '0 : slot_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         slot_ff      <= '0;
         col_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_ff      <= slot_in;
         col_ff       <= col_in;
      end
   end

   // ring bookkeeping: write index, previous sample, entry valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         prev_ff   <= '0;
         valid_ff  <= '0;
      end else if (add_go) begin
         wr_idx_ff           <= (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + 1'b1;
         prev_ff             <= req_sample;
         valid_ff[wr_idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= HEIGHT_LIMIT_RESET;
         scale_ff <= FULL_SCALE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HEIGHT_LIMIT: limit_ff <= csr_data[HEIGHT_W-1:0];
            CSR_FULL_SCALE:   scale_ff <= csr_data;
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         entry_ok_ff <= valid_ff[slot_ff];
      end
      rsp_column_ff <= rsp_column_in;
      rsp_height_ff <= rsp_height_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_column     = rsp_column_ff;
   assign rsp_bar_height = rsp_height_ff;
   assign rsp_last       = rsp_last_ff;

   `DHBG_ASSERT_NEXT(a_draw_busy, clock, reset, accept && (req_kind == KIND_DRAW), busy, "draw not started")
   `DHBG_ASSERT_NEXT(a_add_free, clock, reset, add_go, !busy, "add left block busy")
   `DHBG_ASSERT_NEXT(a_rsp_pulse, clock, reset, rsp_valid, !rsp_valid, "strobe held two cycles")
   `DHBG_ASSERT_SAME(a_last_col, clock, reset, rsp_valid && rsp_last, rsp_column == COLUMN_W'(DEPTH - 1), "last bar at wrong column")
   `DHBG_ASSERT_SAME(a_div_quiet, clock, reset, state_ff != ST_DIV, !div_status.busy, "divider busy")

endmodule

`default_nettype wire
